// ----- rtl/spts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spts_pkg
// Shared types and constants for the serial port transfer sequencer.
// ----------------------------------------------------------------------------
package spts_pkg;

    localparam int NUM_PORTS = 16;
    localparam int LEN_BITS  = 9;

    localparam int IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int PTR_W = $clog2(NUM_PORTS + 1);

    localparam int S_DATA_W = 40;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 24;

    typedef logic [LEN_BITS-1:0] len_t;
    typedef logic [PTR_W-1:0]    ptr_t;
    typedef logic [IDX_W-1:0]    idx_t;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_CTRL = 2'd1,
        OP_PORT = 2'd2,
        OP_NOP  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        STALL_NONE       = 3'd0,
        STALL_PORT_LATCH = 3'd1,
        STALL_TX_READY   = 3'd2,
        STALL_FIFO_EMPTY = 3'd3,
        STALL_PAD_READY  = 3'd4,
        STALL_FIFO_FULL  = 3'd5,
        STALL_RX_EMPTY   = 3'd6
    } stall_t;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       rx_avail;
        logic       fifo_has_space;
        logic       fifo_has_data;
        logic       tx_ready_two;
        logic       tx_ready_one;
        logic       direction;
        logic [1:0] pad_port;
        logic [8:0] buffer_size;
        logic [8:0] send_len;
        logic [3:0] port_index;
    } in_word_t;

    typedef struct packed {
        stall_t     stall_code;
        logic [4:0] current_port;
        logic       busy_res;
        logic       irq;
        logic [7:0] byte_out;
        logic       rx_write;
        logic       tx_write;
        logic [1:0] pad_value;
        logic       pad_write;
        logic       serial_reset;
    } out_word_t;

endpackage

// ----- rtl/serial_port_transfer_sequencer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_port_transfer_sequencer_unit
// Sequences per-port byte transfers between a FIFO and a serial unit.
// ----------------------------------------------------------------------------
//
//  channel | signals                          | payload
//  --------+----------------------------------+------------------------------
//  input   | s_tvalid s_tready s_tdata s_tuser| opcode in tuser, fields in tdata
//  output  | m_tvalid m_tready m_tdata        | one result word per input word
//
//  one word per cycle; each word is decoded and applied to the sequencer state
//  in the accept cycle and its result lands in the output register the cycle after
//  s_tready drops only while the output register is full and m_tready is low
//  reset clears the sequencer state and all per-port tables to zero
//
module serial_port_transfer_sequencer_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // port_index, send_len, buffer_size, pad_port, direction, tx_ready_one,
    // tx_ready_two, fifo_has_data, fifo_has_space, rx_avail, byte_in, pad
    input  logic [spts_pkg::S_DATA_W-1:0] s_tdata,
    // opcode
    input  logic [spts_pkg::S_USER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // serial_reset, pad_write, pad_value, tx_write, rx_write, byte_out, irq,
    // busy_res, current_port, stall_code
    output logic [spts_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int N = spts_pkg::NUM_PORTS;

    spts_pkg::in_word_t  in_w;
    spts_pkg::opcode_t   op;
    spts_pkg::out_word_t res;
    logic                accept;

    logic            ctrl_pending_reg,  ctrl_pending_next;
    logic            pend_dir_reg,      pend_dir_next;
    logic            active_reg,        active_next;
    logic            active_dir_reg,    active_dir_next;
    spts_pkg::ptr_t  ptr_reg,           ptr_next;
    spts_pkg::len_t  count_reg,         count_next;
    spts_pkg::len_t  cmd_len_reg  [N];
    spts_pkg::len_t  cmd_len_next [N];
    spts_pkg::len_t  buf_size_reg [N];
    spts_pkg::len_t  buf_size_next[N];
    logic [1:0]      pad_reg      [N];
    logic [1:0]      pad_next     [N];
    logic [N-1:0]    latch_reg,   latch_next;
    logic [N-1:0]    started_reg, started_next;

    logic                m_tvalid_reg;
    spts_pkg::out_word_t m_tdata_reg;

    assign in_w     = spts_pkg::in_word_t'(s_tdata[$bits(spts_pkg::in_word_t)-1:0]);
    assign op       = spts_pkg::opcode_t'(s_tuser);
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        spts_pkg::idx_t wi;
        spts_pkg::idx_t pi;
        spts_pkg::len_t len;
        logic           ok;
        logic           move;

        ctrl_pending_next = ctrl_pending_reg;
        pend_dir_next     = pend_dir_reg;
        active_next       = active_reg;
        active_dir_next   = active_dir_reg;
        ptr_next          = ptr_reg;
        count_next        = count_reg;
        cmd_len_next      = cmd_len_reg;
        buf_size_next     = buf_size_reg;
        pad_next          = pad_reg;
        latch_next        = latch_reg;
        started_next      = started_reg;
        res               = '0;
        res.stall_code    = spts_pkg::STALL_NONE;
        wi                = spts_pkg::IDX_W'(in_w.port_index);
        pi                = ptr_reg[spts_pkg::IDX_W-1:0];
        len               = '0;
        ok                = 1'b0;
        move              = 1'b0;

        if (accept)
        begin
            unique case (op)
                spts_pkg::OP_CTRL:
                begin
                    ctrl_pending_next = 1'b1;
                    pend_dir_next     = in_w.direction;
                end
                spts_pkg::OP_PORT:
                begin
                    if ({2'b00, in_w.port_index} < 6'(N))
                    begin
                        cmd_len_next[wi]  = spts_pkg::LEN_BITS'(in_w.send_len);
                        buf_size_next[wi] = spts_pkg::LEN_BITS'(in_w.buffer_size);
                        pad_next[wi]      = in_w.pad_port;
                        latch_next[wi]    = 1'b1;
                    end
                end
                spts_pkg::OP_TICK:
                begin
                    // a pending start takes effect before this tick's byte
                    if (ctrl_pending_reg && !active_reg)
                    begin
                        ptr_next          = '0;
                        count_next        = '0;
                        active_next       = 1'b1;
                        active_dir_next   = pend_dir_reg;
                        res.serial_reset  = pend_dir_reg;
                        pend_dir_next     = 1'b0;
                        ctrl_pending_next = 1'b0;
                    end
                    if (active_next)
                    begin
                        pi = ptr_next[spts_pkg::IDX_W-1:0];
                        if (ptr_next < spts_pkg::PTR_W'(N))
                        begin
                            ok = 1'b1;
                            if (!started_reg[pi])
                            begin
                                if (!latch_reg[pi])
                                begin
                                    res.stall_code = spts_pkg::STALL_PORT_LATCH;
                                    ok             = 1'b0;
                                end
                                else
                                begin
                                    started_next[pi] = 1'b1;
                                    latch_next[pi]   = 1'b0;
                                end
                            end
                            if (ok)
                            begin
                                len = active_dir_next ? cmd_len_reg[pi] : buf_size_reg[pi];
                                if (count_next != len)
                                begin
                                    if (active_dir_next)
                                    begin
                                        priority if (!in_w.tx_ready_one)
                                            res.stall_code = spts_pkg::STALL_TX_READY;
                                        else if (!in_w.fifo_has_data)
                                            res.stall_code = spts_pkg::STALL_FIFO_EMPTY;
                                        else if (count_next == '0 && !in_w.tx_ready_two)
                                            res.stall_code = spts_pkg::STALL_PAD_READY;
                                        else
                                            move = 1'b1;
                                        if (move)
                                        begin
                                            res.tx_write = 1'b1;
                                            // first byte of a port also selects the pad
                                            if (count_next == '0)
                                            begin
                                                res.pad_write = 1'b1;
                                                res.pad_value = pad_reg[pi];
                                            end
                                        end
                                    end
                                    else
                                    begin
                                        priority if (!in_w.fifo_has_space)
                                            res.stall_code = spts_pkg::STALL_FIFO_FULL;
                                        else if (!in_w.rx_avail)
                                            res.stall_code = spts_pkg::STALL_RX_EMPTY;
                                        else
                                            move = 1'b1;
                                        res.rx_write = move;
                                    end
                                    ok = move;
                                    if (move)
                                    begin
                                        res.byte_out = in_w.byte_in;
                                        count_next   = count_next + 1'b1;
                                    end
                                end
                                if (ok && count_next == len)
                                begin
                                    if (!active_dir_next)
                                        started_next[pi] = 1'b0;
                                    ptr_next   = ptr_next + 1'b1;
                                    count_next = '0;
                                end
                            end
                        end
                        if (ptr_next >= spts_pkg::PTR_W'(N))
                        begin
                            res.irq     = !active_dir_next;
                            active_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        res.busy_res     = active_next;
        res.current_port = 5'(ptr_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_pending_reg <= 1'b0;
            pend_dir_reg     <= 1'b0;
            active_reg       <= 1'b0;
            active_dir_reg   <= 1'b0;
            ptr_reg          <= '0;
            count_reg        <= '0;
            latch_reg        <= '0;
            started_reg      <= '0;
            m_tvalid_reg     <= 1'b0;
            for (int i = 0; i < N; i++)
            begin
                cmd_len_reg[i]  <= '0;
                buf_size_reg[i] <= '0;
                pad_reg[i]      <= '0;
            end
        end
        else
        begin
            ctrl_pending_reg <= ctrl_pending_next;
            pend_dir_reg     <= pend_dir_next;
            active_reg       <= active_next;
            active_dir_reg   <= active_dir_next;
            ptr_reg          <= ptr_next;
            count_reg        <= count_next;
            latch_reg        <= latch_next;
            started_reg      <= started_next;
            cmd_len_reg      <= cmd_len_next;
            buf_size_reg     <= buf_size_next;
            pad_reg          <= pad_next;
            if (accept)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            m_tdata_reg <= res;
    end

endmodule

// ----- rtl/spts_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spts_checker
// Port-level checks for the serial port transfer sequencer.
// ----------------------------------------------------------------------------
module spts_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [spts_pkg::S_DATA_W-1:0] s_tdata,
    input logic [spts_pkg::S_USER_W-1:0] s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [spts_pkg::M_DATA_W-1:0] m_tdata
);

    spts_pkg::out_word_t res;
    assign res = spts_pkg::out_word_t'(m_tdata);

    // a held result word stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // every accepted word yields a result word next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted word produced no result");

    a_stall_no_move: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.stall_code != spts_pkg::STALL_NONE |-> !res.tx_write && !res.rx_write)
        else $error("byte moved on a stalled tick");

    a_pad_with_tx: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.pad_write |-> res.tx_write && !res.rx_write)
        else $error("pad write without a tx byte");

    a_irq_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.irq |-> !res.busy_res && !res.tx_write)
        else $error("interrupt while still busy");

endmodule

bind serial_port_transfer_sequencer_unit spts_checker u_spts_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/sv/serial_port_transfer_sequencer_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_port_transfer_sequencer_unit_test
// Drives control writes, port register writes, ticks and no-ops into the sequencer and
// checks every result word against an untimed model of the port sequencing,
// with random idle bursts on both stream sides.
// ----------------------------------------------------------------------------
module serial_port_transfer_sequencer_unit_test;

    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_WORDS = 550;
    localparam int QUIET_AFTER = 470;

    class sequencer_scoreboard;
        bit                  ctrl_pend;
        bit                  pend_dir;
        bit                  active;
        bit                  act_dir;
        spts_pkg::ptr_t      ptr;
        spts_pkg::len_t      count;
        spts_pkg::len_t      cmd_len [spts_pkg::NUM_PORTS];
        spts_pkg::len_t      buf_size [spts_pkg::NUM_PORTS];
        logic [1:0]          pad [spts_pkg::NUM_PORTS];
        bit                  latch [spts_pkg::NUM_PORTS];
        bit                  started [spts_pkg::NUM_PORTS];
        spts_pkg::out_word_t res;
        spts_pkg::out_word_t pending_results [$];
        int                  errors;
        int                  checked;

        function new();
            ctrl_pend = 0;
            pend_dir  = 0;
            active    = 0;
            act_dir   = 0;
            ptr       = '0;
            count     = '0;
            errors    = 0;
            checked   = 0;
            for (int p = 0; p < spts_pkg::NUM_PORTS; p++)
            begin
                cmd_len[p]  = '0;
                buf_size[p] = '0;
                pad[p]      = '0;
                latch[p]    = 0;
                started[p]  = 0;
            end
        endfunction

        function void serve_port(spts_pkg::in_word_t w);
            spts_pkg::idx_t p;
            spts_pkg::len_t len;
            if (ptr >= spts_pkg::NUM_PORTS)
                return;
            p = spts_pkg::idx_t'(ptr);
            if (!started[p])
            begin
                if (!latch[p])
                begin
                    res.stall_code = spts_pkg::STALL_PORT_LATCH;
                    return;
                end
                started[p] = 1;
                latch[p]   = 0;
            end
            if (act_dir)
            begin
                len = cmd_len[p];
                if (count != len)
                begin
                    if (!w.tx_ready_one)
                    begin
                        res.stall_code = spts_pkg::STALL_TX_READY;
                        return;
                    end
                    if (!w.fifo_has_data)
                    begin
                        res.stall_code = spts_pkg::STALL_FIFO_EMPTY;
                        return;
                    end
                    // pad port goes out with the first byte of the port
                    if (count == 0)
                    begin
                        if (!w.tx_ready_two)
                        begin
                            res.stall_code = spts_pkg::STALL_PAD_READY;
                            return;
                        end
                        res.pad_write = 1'b1;
                        res.pad_value = pad[p];
                    end
                    res.tx_write = 1'b1;
                    res.byte_out = w.byte_in;
                    count        = count + 1'b1;
                end
                if (count == len)
                begin
                    ptr   = ptr + 1'b1;
                    count = '0;
                end
            end
            else
            begin
                len = buf_size[p];
                if (count != len)
                begin
                    if (!w.fifo_has_space)
                    begin
                        res.stall_code = spts_pkg::STALL_FIFO_FULL;
                        return;
                    end
                    if (!w.rx_avail)
                    begin
                        res.stall_code = spts_pkg::STALL_RX_EMPTY;
                        return;
                    end
                    res.rx_write = 1'b1;
                    res.byte_out = w.byte_in;
                    count        = count + 1'b1;
                end
                if (count == len)
                begin
                    started[p] = 0;
                    ptr        = ptr + 1'b1;
                    count      = '0;
                end
            end
        endfunction

        function void note_word(spts_pkg::opcode_t op, spts_pkg::in_word_t w);
            res = '0;
            case (op)
                spts_pkg::OP_CTRL:
                begin
                    ctrl_pend = 1;
                    pend_dir  = w.direction;
                end
                spts_pkg::OP_PORT:
                begin
                    cmd_len[w.port_index]  = w.send_len;
                    buf_size[w.port_index] = w.buffer_size;
                    pad[w.port_index]      = w.pad_port;
                    latch[w.port_index]    = 1;
                end
                spts_pkg::OP_TICK:
                begin
                    if (ctrl_pend && !active)
                    begin
                        ptr              = '0;
                        count            = '0;
                        active           = 1;
                        act_dir          = pend_dir;
                        res.serial_reset = act_dir;
                        pend_dir         = 0;
                        ctrl_pend        = 0;
                    end
                    if (active)
                    begin
                        serve_port(w);
                        if (ptr >= spts_pkg::NUM_PORTS)
                        begin
                            res.irq = !act_dir;
                            active  = 0;
                        end
                    end
                end
                default: ;
            endcase
            res.busy_res     = active;
            res.current_port = 5'(ptr);
            pending_results.push_back(res);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 200)
                $display("ERROR: %s", msg);
        endtask

        task check_word(spts_pkg::out_word_t got);
            spts_pkg::out_word_t want;
            string               bad;
            checked++;
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with nothing expected", checked));
                return;
            end
            want = pending_results.pop_front();
            bad  = "";
            if (got.serial_reset !== want.serial_reset) bad = {bad, " serial_reset"};
            if (got.pad_write !== want.pad_write)       bad = {bad, " pad_write"};
            if (got.pad_value !== want.pad_value)       bad = {bad, " pad_value"};
            if (got.tx_write !== want.tx_write)         bad = {bad, " tx_write"};
            if (got.rx_write !== want.rx_write)         bad = {bad, " rx_write"};
            if (got.byte_out !== want.byte_out)         bad = {bad, " byte_out"};
            if (got.irq !== want.irq)                   bad = {bad, " irq"};
            if (got.busy_res !== want.busy_res)         bad = {bad, " busy_res"};
            if (got.current_port !== want.current_port) bad = {bad, " current_port"};
            if (got.stall_code !== want.stall_code)     bad = {bad, " stall_code"};
            if (bad != "")
                report_mismatch($sformatf("result %0d:%s got %h want %h",
                                          checked, bad, got, want));
        endtask
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [spts_pkg::S_DATA_W-1:0] s_tdata;
    logic [spts_pkg::S_USER_W-1:0] s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [spts_pkg::M_DATA_W-1:0] m_tdata;

    sequencer_scoreboard sb = new();
    bit quiet = 0;
    int work_words = 0;
    int cycles = 0;

    serial_port_transfer_sequencer_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_word(m_tdata);
    end

    // result side: ready runs broken by stall bursts until the quiet stretch
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            m_tready <= 1'b1;
            if (quiet)
                @(posedge clk);
            else
            begin
                repeat ($urandom_range(1, 25)) @(posedge clk);
                if ($urandom_range(0, 2) != 0)
                begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 19)) @(posedge clk);
                end
            end
        end
    end

    function automatic spts_pkg::in_word_t rand_word();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[$bits(spts_pkg::in_word_t)-1:0];
    endfunction

    // handshake flags each drop with the given percentage
    function automatic spts_pkg::in_word_t tick_word(int stall_pct);
        spts_pkg::in_word_t w;
        w = rand_word();
        w.tx_ready_one   = ($urandom_range(0, 99) >= stall_pct);
        w.tx_ready_two   = ($urandom_range(0, 99) >= stall_pct);
        w.fifo_has_data  = ($urandom_range(0, 99) >= stall_pct);
        w.fifo_has_space = ($urandom_range(0, 99) >= stall_pct);
        w.rx_avail       = ($urandom_range(0, 99) >= stall_pct);
        return w;
    endfunction

    function automatic spts_pkg::in_word_t port_word(spts_pkg::idx_t idx, spts_pkg::len_t cmd,
                                                     spts_pkg::len_t bsz, logic [1:0] pv);
        spts_pkg::in_word_t w;
        w = rand_word();
        w.port_index  = idx;
        w.send_len    = cmd;
        w.buffer_size = bsz;
        w.pad_port    = pv;
        return w;
    endfunction

    function automatic spts_pkg::in_word_t ctrl_word(logic dir);
        spts_pkg::in_word_t w;
        w = rand_word();
        w.direction = dir;
        return w;
    endfunction

    // mostly short ports so that whole transfers finish often
    function automatic spts_pkg::len_t pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return spts_pkg::len_t'($urandom_range(0, 3));
        else if (r < 95)
            return spts_pkg::len_t'($urandom_range(4, 12));
        else if (r < 98)
            return spts_pkg::len_t'($urandom_range(13, 60));
        return spts_pkg::len_t'($urandom_range(0, 511));
    endfunction

    task automatic send_word(spts_pkg::opcode_t op, spts_pkg::in_word_t w);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(spts_pkg::S_DATA_W - $bits(spts_pkg::in_word_t)){1'b0}}, w};
        forever
        begin
            @(posedge clk);
            if (s_tready)
                break;
        end
        if (op != spts_pkg::OP_NOP && (op != spts_pkg::OP_TICK || sb.active || sb.ctrl_pend))
            work_words++;
        sb.note_word(op, w);
    endtask

    task automatic program_ports();
        for (int p = 0; p < spts_pkg::NUM_PORTS; p++)
        begin
            if ($urandom_range(0, 99) < 85)
                send_word(spts_pkg::OP_PORT,
                          port_word(spts_pkg::idx_t'(p), pick_len(), pick_len(),
                                    2'($urandom_range(0, 3))));
        end
    endtask

    initial
    begin
        spts_pkg::in_word_t w;
        int                 r;
        spts_pkg::idx_t     cur;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle tick, no-op, tx start without latch, every tx stall
        send_word(spts_pkg::OP_TICK, tick_word(0));
        send_word(spts_pkg::OP_NOP, rand_word());
        send_word(spts_pkg::OP_CTRL, ctrl_word(1'b1));
        send_word(spts_pkg::OP_TICK, tick_word(0));
        send_word(spts_pkg::OP_PORT, port_word(4'd0, 9'd2, 9'd0, 2'd3));
        w = tick_word(0);
        w.tx_ready_one = 1'b0;
        send_word(spts_pkg::OP_TICK, w);
        w = tick_word(0);
        w.fifo_has_data = 1'b0;
        send_word(spts_pkg::OP_TICK, w);
        w = tick_word(0);
        w.tx_ready_two = 1'b0;
        send_word(spts_pkg::OP_TICK, w);
        w = tick_word(0);
        w.byte_in = 8'hff;
        send_word(spts_pkg::OP_TICK, w);
        // second byte of a port does not wait for pad ready
        w = tick_word(0);
        w.byte_in = 8'h00;
        w.tx_ready_two = 1'b0;
        send_word(spts_pkg::OP_TICK, w);
        // rx request while tx runs stays pending
        send_word(spts_pkg::OP_CTRL, ctrl_word(1'b0));
        send_word(spts_pkg::OP_TICK, tick_word(0));
        // zero length port finishes on its first served tick
        send_word(spts_pkg::OP_PORT, port_word(4'd1, 9'd0, 9'd0, 2'd0));
        send_word(spts_pkg::OP_TICK, tick_word(0));
        send_word(spts_pkg::OP_PORT, port_word(4'd15, 9'd511, 9'd511, 2'd3));
        send_word(spts_pkg::OP_PORT, port_word(4'd15, 9'd1, 9'd1, 2'd2));

        while (work_words < RANDOM_WORDS)
        begin
            if (work_words > QUIET_AFTER)
                quiet = 1;
            r = $urandom_range(0, 99);
            if (sb.active)
            begin
                cur = spts_pkg::idx_t'(sb.ptr);
                if (r < 2 && sb.ptr < spts_pkg::NUM_PORTS)
                    // rewrite of the running port, can leave the count past the length
                    send_word(spts_pkg::OP_PORT, port_word(cur, pick_len(), pick_len(),
                                                           2'($urandom_range(0, 3))));
                else if (r < 4)
                    send_word(spts_pkg::OP_CTRL, ctrl_word(1'($urandom_range(0, 1))));
                else if (r < 6)
                    send_word(spts_pkg::opcode_t'($urandom_range(0, 3)), rand_word());
                else if (r < 40 && sb.ptr < spts_pkg::NUM_PORTS && !sb.started[cur]
                         && !sb.latch[cur])
                    send_word(spts_pkg::OP_PORT, port_word(cur, pick_len(), pick_len(),
                                                           2'($urandom_range(0, 3))));
                else
                    send_word(spts_pkg::OP_TICK, tick_word(15));
            end
            else if (sb.ctrl_pend)
                send_word(spts_pkg::OP_TICK, tick_word(15));
            else if (r < 15)
                send_word(spts_pkg::opcode_t'($urandom_range(0, 3)), rand_word());
            else
            begin
                program_ports();
                send_word(spts_pkg::OP_CTRL, ctrl_word(1'($urandom_range(0, 1))));
            end
        end

        s_tvalid <= 1'b0;
        quiet = 1;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
